>>> rtl/core/gaa_pkg.sv
package gaa_pkg;

    // Default sizes
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_ANTS = 8;

    // Largest number of ants stepped by one step command
    localparam int ANT_LIMIT = 8;

    // Config port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 9;

    localparam logic [CFG_IW-1:0] CFG_COLS_USED   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROWS_USED   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ACTIVE_ANTS = 2'd2;

    // Command codes
    localparam logic [1:0] CMD_PLACE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Headings
    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] ant_index;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [1:0] heading;
    } gaa_req_t;

    typedef struct packed {
        logic [2:0] ant_id;
        logic [7:0] ant_col;
        logic [7:0] ant_row;
        logic [1:0] ant_heading;
        logic       cell_value;
        logic       bad_request;
        logic       last;
    } gaa_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_RQ,
        ST_REPLY,
        ST_STEP_RD,
        ST_STEP_WR
    } gaa_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic rd_req;
        logic reply;
        logic step_wr;
    } gaa_ctl_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic last_ant;
    } gaa_stat_t;

endpackage

>>> rtl/core/gaa_ram.sv
module gaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/gaa_ctrl.sv
module gaa_ctrl
    import gaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_cmd,
    output logic       req_ready,
    input  gaa_stat_t  stat,
    output gaa_ctl_t   ctl
);

    gaa_state_t state_reg;
    gaa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_cmd)
                        CMD_STEP: state_next = ST_STEP_RD;
                        CMD_READ: state_next = ST_READ_RQ;
                        default:  state_next = ST_REPLY;
                    endcase
                end
            end
            ST_READ_RQ:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP_RD:
            begin
                state_next = ST_STEP_WR;
            end
            ST_STEP_WR:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_ant ? ST_IDLE : ST_STEP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                ctl.load_in = req_valid;
            end
            ST_READ_RQ:
            begin
                ctl.rd_req = 1'b1;
            end
            ST_REPLY:
            begin
                ctl.reply = stat.out_free;
            end
            ST_STEP_RD:
            begin
                ctl.rd_req = 1'b1;
            end
            ST_STEP_WR:
            begin
                ctl.step_wr = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/gaa_datapath.sv
module gaa_datapath
    import gaa_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_ANTS = DEF_MAX_ANTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gaa_req_t          req,
    input  logic              cfg_valid,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gaa_rsp_t          rsp,
    input  gaa_ctl_t          ctl,
    output gaa_stat_t         stat
);

    localparam int CW        = $clog2(MAX_COLS);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int BW_W      = $clog2(MAX_COLS + 1);
    localparam int BH_W      = $clog2(MAX_ROWS + 1);
    localparam int ANT_SLOTS = (MAX_ANTS < ANT_LIMIT) ? MAX_ANTS : ANT_LIMIT;
    localparam int AIW       = (ANT_SLOTS > 1) ? $clog2(ANT_SLOTS) : 1;
    localparam int BW_RST    = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int BH_RST    = (MAX_ROWS < 256) ? MAX_ROWS : 256;

    // Configuration
    logic [BW_W-1:0] bw_reg, bw_next;
    logic [BH_W-1:0] bh_reg, bh_next;
    logic [3:0]      act_reg, act_next;

    always_comb
    begin
        bw_next  = bw_reg;
        bh_next  = bh_reg;
        act_next = act_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLS_USED:
                begin
                    if (cfg_data == '0)
                        bw_next = BW_W'(1);
                    else if (32'(cfg_data) > MAX_COLS)
                        bw_next = BW_W'(MAX_COLS);
                    else
                        bw_next = BW_W'(cfg_data);
                end
                CFG_ROWS_USED:
                begin
                    if (cfg_data == '0)
                        bh_next = BH_W'(1);
                    else if (32'(cfg_data) > MAX_ROWS)
                        bh_next = BH_W'(MAX_ROWS);
                    else
                        bh_next = BH_W'(cfg_data);
                end
                CFG_ACTIVE_ANTS:
                begin
                    if (cfg_data[3:0] == 4'd0)
                        act_next = 4'd1;
                    else if (32'(cfg_data[3:0]) > ANT_SLOTS)
                        act_next = 4'(ANT_SLOTS);
                    else
                        act_next = cfg_data[3:0];
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    // Latched request, ant counter, clear sweep row
    gaa_req_t        req_reg, req_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [RW-1:0]   clr_reg, clr_next;

    // Ant slots
    logic [CW-1:0] col_reg  [ANT_SLOTS];
    logic [RW-1:0] row_reg  [ANT_SLOTS];
    logic [1:0]    head_reg [ANT_SLOTS];
    logic [CW-1:0] col_next [ANT_SLOTS];
    logic [RW-1:0] row_next [ANT_SLOTS];
    logic [1:0]    head_next[ANT_SLOTS];

    // Result register
    logic     rsp_valid_reg, rsp_valid_next;
    gaa_rsp_t rsp_reg, rsp_next;

    // Grid memory, one word per row
    logic                ram_we;
    logic [RW-1:0]       ram_wr_addr;
    logic [MAX_COLS-1:0] ram_wr_data;
    logic [RW-1:0]       ram_rd_addr;
    logic [MAX_COLS-1:0] row_q;

    // Step arithmetic for the current ant
    logic [AIW-1:0] ai;
    logic [CW-1:0]  ax, x_new;
    logic [RW-1:0]  ay, y_new;
    logic [1:0]     ah, h_new;
    logic           v_new;
    logic           last_ant;

    // Request checks
    logic           place_bad;
    logic           read_bad;
    logic           slot_bad;

    assign ai = cnt_reg[AIW-1:0];

    always_comb
    begin
        ax = (col_reg[ai] >= bw_reg) ? '0 : col_reg[ai];
        ay = (row_reg[ai] >= bh_reg) ? '0 : row_reg[ai];
        ah = head_reg[ai];
        v_new = ~row_q[ax];
        h_new = v_new ? (ah + 2'd1) : (ah - 2'd1);
        x_new = ax;
        y_new = ay;
        case (h_new)
            HEAD_NORTH: y_new = (ay == '0) ? RW'(bh_reg - 1'b1) : (ay - 1'b1);
            HEAD_SOUTH: y_new = ((BH_W'(ay) + 1'b1) >= bh_reg) ? '0 : (ay + 1'b1);
            HEAD_EAST:  x_new = ((BW_W'(ax) + 1'b1) >= bw_reg) ? '0 : (ax + 1'b1);
            HEAD_WEST:  x_new = (ax == '0) ? CW'(bw_reg - 1'b1) : (ax - 1'b1);
            default:    x_new = ax;
        endcase
        last_ant = (({1'b0, cnt_reg} + 4'd1) >= act_reg);
    end

    assign slot_bad  = (32'(req_reg.ant_index) >= MAX_ANTS);
    assign read_bad  = (req_reg.pos_x >= bw_reg) || (req_reg.pos_y >= bh_reg);
    assign place_bad = slot_bad || read_bad;

    // Memory ports
    always_comb
    begin
        ram_we      = ctl.clear_wr || ctl.step_wr;
        ram_wr_addr = ctl.clear_wr ? clr_reg : ay;
        ram_wr_data = ctl.clear_wr ? '0 : (row_q ^ (MAX_COLS'(1) << ax));
        ram_rd_addr = (req_reg.cmd == CMD_STEP) ? ay : RW'(req_reg.pos_y);
    end

    gaa_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ctl.rd_req),
        .rd_addr (ram_rd_addr),
        .rd_data (row_q)
    );

    // Sequencing state and ant slots
    always_comb
    begin
        req_next  = req_reg;
        cnt_next  = cnt_reg;
        clr_next  = clr_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        head_next = head_reg;
        if (ctl.load_in)
        begin
            req_next = req;
            cnt_next = '0;
        end
        if (ctl.clear_wr)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (ctl.reply && (req_reg.cmd == CMD_PLACE) && !place_bad)
        begin
            col_next[req_reg.ant_index[AIW-1:0]]  = CW'(req_reg.pos_x);
            row_next[req_reg.ant_index[AIW-1:0]]  = RW'(req_reg.pos_y);
            head_next[req_reg.ant_index[AIW-1:0]] = req_reg.heading;
        end
        if (ctl.step_wr)
        begin
            col_next[ai]  = x_new;
            row_next[ai]  = y_new;
            head_next[ai] = h_new;
            cnt_next      = cnt_reg + 3'd1;
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (ctl.reply)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            rsp_next.last  = 1'b1;
            case (req_reg.cmd)
                CMD_PLACE:
                begin
                    rsp_next.ant_id      = req_reg.ant_index;
                    rsp_next.ant_col     = req_reg.pos_x;
                    rsp_next.ant_row     = req_reg.pos_y;
                    rsp_next.ant_heading = req_reg.heading;
                    rsp_next.bad_request = place_bad;
                end
                CMD_READ:
                begin
                    rsp_next.ant_col     = req_reg.pos_x;
                    rsp_next.ant_row     = req_reg.pos_y;
                    rsp_next.cell_value  = read_bad ? 1'b0 : row_q[CW'(req_reg.pos_x)];
                    rsp_next.bad_request = read_bad;
                end
                default:
                begin
                    rsp_next.bad_request = 1'b1;
                end
            endcase
        end
        else if (ctl.step_wr)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.ant_id      = cnt_reg;
            rsp_next.ant_col     = 8'(x_new);
            rsp_next.ant_row     = 8'(y_new);
            rsp_next.ant_heading = h_new;
            rsp_next.cell_value  = v_new;
            rsp_next.bad_request = 1'b0;
            rsp_next.last        = last_ant;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg        <= BW_W'(BW_RST);
            bh_reg        <= BH_W'(BH_RST);
            act_reg       <= 4'd1;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ANT_SLOTS; i++)
            begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                head_reg[i] <= HEAD_NORTH;
            end
        end
        else
        begin
            bw_reg        <= bw_next;
            bh_reg        <= bh_next;
            act_reg       <= act_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign stat.clear_done = (clr_reg == RW'(MAX_ROWS - 1));
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign stat.last_ant   = last_ant;

endmodule

>>> rtl/core/grid_ant_automaton.sv
// Langton's ant engine on a toroidal one-bit grid of MAX_COLS x MAX_ROWS cells
// with up to eight ant slots. Each request transfer on req gives one or more
// response transfers on rsp; the last one of a request has rsp.last set.
// Place (cmd 0) and unknown commands go straight to the reply, read (cmd 2)
// first reads the grid row, and step (cmd 1) does a row read and then a row
// write for each active ant in turn. The pace of a step is set by the
// grid memory: every ant does a read of its row followed by a write of the
// toggled row on the single read and single write port, and the next ant
// reads only after that write so it sees the toggle. A result waits in an
// output register; the block holds off further work only when that register
// is still full. After reset the grid is cleared one row per cycle, during
// which req_ready stays low; configuration writes are taken at any time but
// should only be issued while idle.
// Registers: 0 columns in use, 1 rows in use, 2 active_ants; out-of-range
// values are clamped.
module grid_ant_automaton
    import gaa_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_ANTS = DEF_MAX_ANTS
) (
    input  logic              clk,
    input  logic              rst_n,

    // Request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  gaa_req_t          req,

    // Response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gaa_rsp_t          rsp,

    // Configuration write channel, always ready
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    gaa_ctl_t  ctl;
    gaa_stat_t stat;

    // Register writes are always accepted and take effect in the next cycle
    assign cfg_ready = 1'b1;

    // Sequencer: clear sweep, command dispatch, per-ant read/write
    gaa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Grid memory, ant slots, config registers and the result register
    gaa_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_ANTS (MAX_ANTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gaa_pkg::*;

    // Codes the package leaves unnamed: the spare opcode and the spare
    // register index. Both must be harmless.
    localparam logic [1:0]        CMD_UNKNOWN = 2'd3;
    localparam logic [CFG_IW-1:0] CFG_SPARE   = 2'd3;

    localparam int GRID_CELLS  = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int ANT_CAP     = (DEF_MAX_ANTS < ANT_LIMIT) ? DEF_MAX_ANTS : ANT_LIMIT;
    localparam int BATCH_ITEMS = 48;
    localparam int BATCHES     = 9;
    localparam int REQ_W       = $bits(gaa_req_t);

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // DUT ports
    logic              req_valid = 1'b0;
    logic              req_ready;
    gaa_req_t          req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    gaa_rsp_t          rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    grid_ant_automaton dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stall rates in percent, changed only while the block is drained
    int send_idle_pct = 15;
    int recv_idle_pct = 53;
    int mismatches    = 0;

    gaa_req_t cmd_backlog[$];   // commands waiting for the driver
    gaa_rsp_t due_reports[$];   // reports the block still owes, oldest first

    // ------------------------------------------------------------------
    // Shadow of the colony: grid, ant slots and the clamped registers.
    // Cells live at row * DEF_MAX_COLS + col whatever the board size, so
    // cells outside a shrunk board survive and reappear when it grows.
    // ------------------------------------------------------------------
    bit          cell_shadow [GRID_CELLS];
    logic [7:0]  ant_x   [DEF_MAX_ANTS];
    logic [7:0]  ant_y   [DEF_MAX_ANTS];
    logic [1:0]  ant_dir [DEF_MAX_ANTS];
    int unsigned board_w = DEF_MAX_COLS;
    int unsigned board_h = DEF_MAX_ROWS;
    int unsigned n_ants  = 1;

    initial
    begin
        for (int i = 0; i < DEF_MAX_ANTS; i++)
        begin
            ant_x[i]   = '0;
            ant_y[i]   = '0;
            ant_dir[i] = HEAD_NORTH;
        end
    end

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Register write as seen by the block; out-of-range values are clamped
    function automatic void store_register(logic [CFG_IW-1:0] idx,
                                           logic [CFG_DW-1:0] val);
        case (idx)
            CFG_COLS_USED:   board_w = clamp_reg(val, DEF_MAX_COLS);
            CFG_ROWS_USED:   board_h = clamp_reg(val, DEF_MAX_ROWS);
            CFG_ACTIVE_ANTS: n_ants  = clamp_reg(val[3:0], ANT_CAP);
            default: ;
        endcase
    endfunction

    // Apply one command to the shadow and queue the reports it owes
    function automatic void run_command(gaa_req_t c);
        gaa_rsp_t    rep;
        int unsigned x;
        int unsigned y;
        int unsigned addr;
        logic [1:0]  dir;
        bit          v;

        rep = '0;
        rep.last = 1'b1;
        case (c.cmd)
            CMD_PLACE:
            begin
                rep.ant_id      = c.ant_index;
                rep.ant_col     = c.pos_x;
                rep.ant_row     = c.pos_y;
                rep.ant_heading = c.heading;
                if (c.ant_index >= DEF_MAX_ANTS || c.pos_x >= board_w || c.pos_y >= board_h)
                    rep.bad_request = 1'b1;
                else
                begin
                    ant_x[c.ant_index]   = c.pos_x;
                    ant_y[c.ant_index]   = c.pos_y;
                    ant_dir[c.ant_index] = c.heading;
                end
                due_reports.push_back(rep);
            end
            CMD_STEP:
            begin
                for (int i = 0; i < n_ants; i++)
                begin
                    // an ant stranded by a shrunk board restarts from coordinate 0
                    x   = (ant_x[i] >= board_w) ? 0 : ant_x[i];
                    y   = (ant_y[i] >= board_h) ? 0 : ant_y[i];
                    addr = y * DEF_MAX_COLS + x;
                    v    = ~cell_shadow[addr];
                    cell_shadow[addr] = v;
                    // set cell: turn right, cleared cell: turn left
                    dir  = v ? ant_dir[i] + 2'd1 : ant_dir[i] - 2'd1;
                    case (dir)
                        HEAD_NORTH: y = (y == 0) ? board_h - 1 : y - 1;
                        HEAD_SOUTH: y = (y + 1 >= board_h) ? 0 : y + 1;
                        HEAD_EAST:  x = (x + 1 >= board_w) ? 0 : x + 1;
                        default:    x = (x == 0) ? board_w - 1 : x - 1;
                    endcase
                    ant_x[i]   = x[7:0];
                    ant_y[i]   = y[7:0];
                    ant_dir[i] = dir;

                    rep             = '0;
                    rep.ant_id      = i[2:0];
                    rep.ant_col     = x[7:0];
                    rep.ant_row     = y[7:0];
                    rep.ant_heading = dir;
                    rep.cell_value  = v;
                    rep.last        = (i + 1 >= n_ants);
                    due_reports.push_back(rep);
                end
            end
            CMD_READ:
            begin
                rep.ant_col = c.pos_x;
                rep.ant_row = c.pos_y;
                if (c.pos_x >= board_w || c.pos_y >= board_h)
                    rep.bad_request = 1'b1;
                else
                    rep.cell_value = cell_shadow[c.pos_y * DEF_MAX_COLS + c.pos_x];
                due_reports.push_back(rep);
            end
            default:
            begin
                rep.bad_request = 1'b1;
                due_reports.push_back(rep);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers the next backlog entry whenever the channel is
    // free, with random gaps. Valid holds with a stable payload until the
    // transfer; the shadow is updated at the transfer edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                run_command(req);
            if (!req_valid || req_ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= cmd_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: random back-pressure, every transfer checked field
    // by field against the oldest owed report.
    // ------------------------------------------------------------------
    task automatic check_report(gaa_rsp_t got);
        gaa_rsp_t want;

        if (due_reports.size() == 0)
        begin
            $error("response %h with no report owed", got);
            mismatches++;
        end
        else
        begin
            want = due_reports.pop_front();
            if (got !== want)
                mismatches++;
            if (got.ant_id !== want.ant_id)
                $error("ant_id: expected %0d, got %0d", want.ant_id, got.ant_id);
            if (got.ant_col !== want.ant_col)
                $error("ant_col: expected %0d, got %0d", want.ant_col, got.ant_col);
            if (got.ant_row !== want.ant_row)
                $error("ant_row: expected %0d, got %0d", want.ant_row, got.ant_row);
            if (got.ant_heading !== want.ant_heading)
                $error("ant_heading: expected %0d, got %0d",
                       want.ant_heading, got.ant_heading);
            if (got.cell_value !== want.cell_value)
                $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
            if (got.bad_request !== want.bad_request)
                $error("bad_request: expected %0d, got %0d",
                       want.bad_request, got.bad_request);
            if (got.last !== want.last)
                $error("last: expected %0d, got %0d", want.last, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
                check_report(rsp);
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_cmd(logic [1:0] c, logic [2:0] slot,
                                      logic [7:0] x, logic [7:0] y, logic [1:0] hd);
        gaa_req_t r;

        r.cmd       = c;
        r.ant_index = slot;
        r.pos_x     = x;
        r.pos_y     = y;
        r.heading   = hd;
        cmd_backlog.push_back(r);
    endfunction

    // Mostly in-board places and reads plus plenty of steps, so ants meet
    // each other's trails; a few off-board requests and spare opcodes.
    function automatic gaa_req_t random_command();
        gaa_req_t r;
        int       pick;

        r    = gaa_req_t'(REQ_W'($urandom));
        pick = $urandom_range(99);
        if (pick < 40)
            r.cmd = CMD_STEP;
        else if (pick < 95)
        begin
            r.cmd = (pick < 65) ? CMD_PLACE : CMD_READ;
            if ($urandom_range(9) != 0)
            begin
                r.pos_x = 8'($urandom_range(board_w - 1));
                r.pos_y = 8'($urandom_range(board_h - 1));
            end
        end
        else
            r.cmd = CMD_UNKNOWN;
        return r;
    endfunction

    // Wait until every command is taken and every report is back
    task automatic quiesce();
        while (cmd_backlog.size() != 0 || req_valid || due_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called while the block is drained
    task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        store_register(idx, val[CFG_DW-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned a;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset board 256 x 256, one ant: corners, heading wrap, spare opcode
        queue_cmd(CMD_READ, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_READ, 3'd0, 8'd255, 8'd255, HEAD_NORTH);
        queue_cmd(CMD_PLACE, 3'd0, 8'd255, 8'd255, HEAD_WEST);
        queue_cmd(CMD_STEP, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_STEP, 3'd7, 8'd255, 8'd255, HEAD_WEST);
        queue_cmd(CMD_READ, 3'd0, 8'd255, 8'd255, HEAD_NORTH);
        queue_cmd(CMD_UNKNOWN, 3'd7, 8'd255, 8'd255, HEAD_WEST);
        queue_cmd(CMD_PLACE, 3'd7, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_PLACE, 3'd3, 8'd128, 8'd64, HEAD_SOUTH);
        queue_cmd(CMD_PLACE, 3'd5, 8'd1, 8'd2, HEAD_EAST);
        quiesce();

        // Shrunk board strands ants; ant count above the cap clamps to 8
        write_reg(CFG_COLS_USED, 100);
        write_reg(CFG_ROWS_USED, 50);
        write_reg(CFG_ACTIVE_ANTS, 15);
        queue_cmd(CMD_PLACE, 3'd1, 8'd100, 8'd10, HEAD_NORTH);
        queue_cmd(CMD_PLACE, 3'd2, 8'd10, 8'd50, HEAD_EAST);
        queue_cmd(CMD_READ, 3'd0, 8'd99, 8'd49, HEAD_NORTH);
        queue_cmd(CMD_READ, 3'd0, 8'd100, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_READ, 3'd0, 8'd0, 8'd200, HEAD_NORTH);
        queue_cmd(CMD_STEP, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_STEP, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        quiesce();

        // Zero width and zero ants clamp to 1, height over range clamps to 256,
        // spare register index must change nothing
        write_reg(CFG_COLS_USED, 0);
        write_reg(CFG_ROWS_USED, 511);
        write_reg(CFG_ACTIVE_ANTS, 0);
        write_reg(CFG_SPARE, 9'h1FF);
        queue_cmd(CMD_PLACE, 3'd0, 8'd0, 8'd255, HEAD_SOUTH);
        queue_cmd(CMD_STEP, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_STEP, 3'd0, 8'd0, 8'd0, HEAD_NORTH);
        queue_cmd(CMD_READ, 3'd0, 8'd0, 8'd255, HEAD_NORTH);
        queue_cmd(CMD_READ, 3'd0, 8'd1, 8'd0, HEAD_NORTH);

        // Random batches, one board setting each. Stall mix: sender light /
        // receiver heavy, then swapped, then no stalls at all.
        for (int b = 0; b < BATCHES; b++)
        begin
            quiesce();
            if (b == 3)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 15;
            end
            if (b == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (b)
                0: begin w = 16;  h = 16;  a = 8; end
                1: begin w = 1;   h = 1;   a = 3; end
                2: begin w = 256; h = 256; a = 8; end
                3: begin w = 2;   h = 256; a = 2; end
                4: begin w = 7;   h = 5;   a = 4; end
                5: begin w = 256; h = 1;   a = 8; end
                6:
                begin
                    w = $urandom_range(1, 32);
                    h = $urandom_range(1, 32);
                    a = $urandom_range(1, 15);
                end
                7: begin w = 200; h = 100; a = 5; end
                default: begin w = 511; h = 256; a = 8; end
            endcase
            write_reg(CFG_COLS_USED, w);
            write_reg(CFG_ROWS_USED, h);
            write_reg(CFG_ACTIVE_ANTS, a);
            for (int k = 0; k < BATCH_ITEMS; k++)
            begin
                // one full hold-off mid-stream: the block must drain and
                // pick up again cleanly
                if (b == 4 && k == BATCH_ITEMS / 2)
                    quiesce();
                cmd_backlog.push_back(random_command());
            end
        end

        quiesce();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("grid_ant_automaton regression: pass");
        else
            $display("grid_ant_automaton regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("grid_ant_automaton regression: fail");
        $finish;
    end

endmodule
